### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/pptr_pkg.sv
`timescale 1ns / 1ps

package pptr_pkg;

   localparam int TAG_W    = 32;
   localparam int CLASS_W  = 6;
   localparam int PRE_W    = 7;
   localparam int POST_W   = 16;
   localparam int MASK_W   = 64;
   localparam int REGIDX_W = 2;

   typedef enum logic [REGIDX_W-1:0] {
      CSR_PRE_COUNT   = 2'd0,
      CSR_POST_COUNT  = 2'd1,
      CSR_WORTHY_MASK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]   frame_tag;
      logic               motion;
      logic [CLASS_W-1:0] object_class;
   } req_payload_type;

   typedef struct packed {
      logic [TAG_W-1:0]   out_tag;
      logic               stop_event;
      logic               first_of_clip;
      logic [CLASS_W-1:0] clip_object;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic [REGIDX_W-1:0] reg_index;
      logic [MASK_W-1:0]   wdata;
   } csr_payload_type;

endpackage

### rtl/core/pptr_chan_if.sv
`timescale 1ns / 1ps

interface pptr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/pre_post_trigger_recorder.sv
// channel  dir  payload                                               handshake
// req_if   in   frame_tag, motion, object_class                       valid/ready
// rsp_if   out  out_tag, stop_event, first_of_clip, clip_object, last valid/ready
// csr_if   in   reg_index, wdata                                      valid/ready
//
// a frame that yields zero or one result is taken in the idle state, with no drain
// a trigger drain of n buffered frames reads each entry from the single registered
// read port of the ring memory, then presents it
// reset is synchronous and clears control state only; ring entries are read only
// inside the fill, so the ring memory has no clearing pass
// rsp back-pressure holds the output register; req_if.ready is low during a drain
// and while the output register is full and not taken
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pre_post_trigger_recorder #(
   parameter int RING_DEPTH = 64,
   parameter int TAG_BITS   = 32
) (
   input logic        clock,
   input logic        reset,
   pptr_chan_if.sink   req_if,
   pptr_chan_if.source rsp_if,
   pptr_chan_if.sink   csr_if
);
   import pptr_pkg::*;

   localparam int PTR_BITS   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_BITS  = $clog2(RING_DEPTH + 1);
   localparam int SUM_BITS   = FILL_BITS + 1;
   localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
   localparam logic [FILL_BITS-1:0] DEPTH_F  = FILL_BITS'(RING_DEPTH);
   localparam logic [SUM_BITS-1:0]  DEPTH_S  = SUM_BITS'(RING_DEPTH);
   localparam logic [PTR_BITS-1:0]  LAST_PTR = PTR_BITS'(RING_DEPTH - 1);
   localparam logic [PRE_W-1:0]     DEPTH_P  = PRE_W'(RING_DEPTH);

   function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // configuration
   logic [PRE_W-1:0]  pre_count_ff;
   logic [POST_W-1:0] post_count_ff;
   logic [MASK_W-1:0] worthy_mask_ff;

   // block state
   state_type          state_ff, state_in;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 rec_ff, rec_in;
   logic [CLASS_W-1:0]   held_ff, held_in;
   logic [POST_W-1:0]    hold_ff, hold_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] cnt_ff, cnt_in;
   logic                 first_ff, first_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      out_ff, out_in;

   // push arithmetic
   logic [FILL_BITS-1:0] keep;
   logic [SUM_BITS-1:0]  wr_sum;
   logic [PTR_BITS-1:0]  wr_addr;
   logic [PTR_BITS-1:0]  head_a, head_b;
   logic [FILL_BITS-1:0] fill_a, fill_b;
   logic [CLASS_W-1:0]   held_sel;
   logic                 trigger;
   logic [STORE_BITS-1:0] tag_store;

   logic                  out_free, req_fire, load_out, wr_en, rd_en;
   logic [STORE_BITS-1:0] rd_data;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_fire  = req_if.valid && req_if.ready;
   assign tag_store = req_if.payload.frame_tag[STORE_BITS-1:0];
   assign keep      = (pre_count_ff > DEPTH_P) ? DEPTH_F : FILL_BITS'(pre_count_ff);

   always_comb begin
      wr_sum = SUM_BITS'(head_ff) + SUM_BITS'(fill_ff);
      if (wr_sum >= DEPTH_S) begin
         wr_sum = wr_sum - DEPTH_S;
      end
      if (fill_ff < DEPTH_F) begin
         wr_addr = wr_sum[PTR_BITS-1:0];
         head_a  = head_ff;
         fill_a  = fill_ff + 1'b1;
      end else begin
         // full ring: overwrite the oldest entry
         wr_addr = head_ff;
         head_a  = ptr_inc(head_ff);
         fill_a  = fill_ff;
      end
      // drop at most one oldest entry per frame
      if (fill_a > keep) begin
         head_b = ptr_inc(head_a);
         fill_b = fill_a - 1'b1;
      end else begin
         head_b = head_a;
         fill_b = fill_a;
      end
      if ((req_if.payload.object_class != '0) &&
          worthy_mask_ff[req_if.payload.object_class]) begin
         held_sel = req_if.payload.object_class;
      end else begin
         held_sel = held_ff;
      end
      trigger = req_if.payload.motion && (held_sel != '0);
   end

   assign req_if.ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      rec_in    = rec_ff;
      held_in   = held_ff;
      hold_in   = hold_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      out_in    = out_ff;
      load_out  = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               wr_en   = 1'b1;
               head_in = head_b;
               fill_in = fill_b;
               held_in = held_sel;
               out_in.out_tag       = TAG_W'(tag_store);
               out_in.stop_event    = 1'b0;
               out_in.first_of_clip = 1'b0;
               out_in.clip_object   = '0;
               out_in.last          = 1'b1;
               if (trigger) begin
                  hold_in = post_count_ff;
                  if (!rec_ff) begin
                     rec_in  = 1'b1;
                     head_in = '0;
                     fill_in = '0;
                     if (fill_b == '0) begin
                        load_out             = 1'b1;
                        out_in.first_of_clip = 1'b1;
                     end else begin
                        // drain oldest first; the current frame is the newest entry
                        state_in  = ST_READ;
                        rd_ptr_in = head_b;
                        cnt_in    = fill_b;
                        first_in  = 1'b1;
                     end
                  end else begin
                     load_out = 1'b1;
                  end
               end else if (rec_ff) begin
                  load_out = 1'b1;
                  if (hold_ff <= POST_W'(1)) begin
                     hold_in            = '0;
                     rec_in             = 1'b0;
                     held_in            = '0;
                     out_in.out_tag     = '0;
                     out_in.stop_event  = 1'b1;
                     out_in.clip_object = held_sel;
                  end else begin
                     hold_in = hold_ff - 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            rd_en     = 1'b1;
            rd_ptr_in = ptr_inc(rd_ptr_ff);
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out             = 1'b1;
               out_in.out_tag       = TAG_W'(rd_data);
               out_in.stop_event    = 1'b0;
               out_in.first_of_clip = first_ff;
               out_in.clip_object   = '0;
               out_in.last          = (cnt_ff == FILL_BITS'(1));
               first_in             = 1'b0;
               cnt_in               = cnt_ff - 1'b1;
               state_in             = (cnt_ff == FILL_BITS'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   pptr_ring_mem #(
      .DEPTH     (RING_DEPTH),
      .WIDTH     (STORE_BITS),
      .ADDR_BITS (PTR_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tag_store),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_count_ff   <= '0;
         post_count_ff  <= '0;
         worthy_mask_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.payload.reg_index)
            CSR_PRE_COUNT:   pre_count_ff   <= csr_if.payload.wdata[PRE_W-1:0];
            CSR_POST_COUNT:  post_count_ff  <= csr_if.payload.wdata[POST_W-1:0];
            CSR_WORTHY_MASK: worthy_mask_ff <= csr_if.payload.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rec_ff       <= 1'b0;
         held_ff      <= '0;
         hold_ff      <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rec_ff       <= rec_in;
         held_ff      <= held_in;
         hold_ff      <= hold_in;
         rd_ptr_ff    <= rd_ptr_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = out_ff;

   `ASSERT_IMPLY(a_drain_has_work, clock, reset, state_ff != ST_IDLE, cnt_ff != '0)
   `ASSERT_IMPLY(a_drain_ring_empty, clock, reset, state_ff != ST_IDLE, rec_ff && (fill_ff == '0))
   `ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= DEPTH_F)
   `ASSERT_NEXT(a_stop_ends_clip, clock, reset, load_out && out_in.stop_event, !rec_ff && (held_ff == '0))

endmodule

### rtl/core/pptr_ring_mem.sv
`timescale 1ns / 1ps

module pptr_ring_mem #(
   parameter int DEPTH     = 64,
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pptr_pkg::*;

   localparam int RING_N = 64;
   localparam logic [REGIDX_W-1:0] CSR_SPARE = 2'd3;   // no register behind this index

   // shadow of the recorder: pre-trigger ring, clip state and the queue of frames owed
   class clip_scoreboard;
      logic [TAG_W-1:0]   ring_mem [RING_N];
      logic [5:0]         ring_head = '0;
      logic [6:0]         ring_fill = '0;
      logic               recording = 1'b0;
      logic [CLASS_W-1:0] held_class = '0;
      logic [POST_W-1:0]  hold_left = '0;
      logic [PRE_W-1:0]   pre_cfg = '0;
      logic [POST_W-1:0]  post_cfg = '0;
      logic [MASK_W-1:0]  mask_cfg = '0;
      rsp_payload_type    clip_q[$];
      int errors, frames, results, clips, stops, writes;

      function void write_reg(logic [REGIDX_W-1:0] idx, logic [MASK_W-1:0] val);
         writes++;
         case (idx)
            CSR_PRE_COUNT:   pre_cfg = val[PRE_W-1:0];
            CSR_POST_COUNT:  post_cfg = val[POST_W-1:0];
            CSR_WORTHY_MASK: mask_cfg = val;
            default: ;
         endcase
      endfunction

      function rsp_payload_type clip_entry(logic [TAG_W-1:0] tag, logic stop, logic first,
                                           logic [CLASS_W-1:0] obj);
         rsp_payload_type r;
         r.out_tag       = tag;
         r.stop_event    = stop;
         r.first_of_clip = first;
         r.clip_object   = obj;
         r.last          = 1'b0;
         return r;
      endfunction

      function void note_frame(req_payload_type f);
         rsp_payload_type burst[$];
         logic [6:0]      keep;
         logic [5:0]      slot;
         keep = (pre_cfg > RING_N) ? 7'(RING_N) : pre_cfg;
         frames++;
         if (ring_fill < RING_N) begin
            slot = ring_head + ring_fill[5:0];
            ring_mem[slot] = f.frame_tag;
            ring_fill++;
         end else begin
            // full ring: overwrite the oldest
            ring_mem[ring_head] = f.frame_tag;
            ring_head++;
         end
         // at most one entry dropped per frame
         if (ring_fill > keep) begin
            ring_head++;
            ring_fill--;
         end
         if (f.object_class != 0 && mask_cfg[f.object_class])
            held_class = f.object_class;
         if (f.motion && held_class != 0) begin
            if (!recording) begin
               for (int unsigned i = 0; i < ring_fill; i++) begin
                  slot = ring_head + 6'(i);
                  burst = {burst, clip_entry(ring_mem[slot], 1'b0, i == 0, '0)};
               end
               if (ring_fill == 0)
                  burst = {burst, clip_entry(f.frame_tag, 1'b0, 1'b1, '0)};
               ring_head = '0;
               ring_fill = '0;
               recording = 1'b1;
               clips++;
            end else begin
               burst = {burst, clip_entry(f.frame_tag, 1'b0, 1'b0, '0)};
            end
            hold_left = post_cfg;
         end else if (recording) begin
            if (hold_left <= 1) begin
               // the stopping frame's tag is not passed on; the stop result carries a zero tag
               hold_left = '0;
               burst = {burst, clip_entry('0, 1'b1, 1'b0, held_class)};
               recording = 1'b0;
               held_class = '0;
               stops++;
            end else begin
               hold_left--;
               burst = {burst, clip_entry(f.frame_tag, 1'b0, 1'b0, '0)};
            end
         end
         if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
         clip_q = {clip_q, burst};
      endfunction

      function void check_field(string what, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 30)
               $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         results++;
         if (clip_q.size() == 0) begin
            errors++;
            if (errors <= 30)
               $display("%0t unexpected transfer: expected none, got tag %h stop %b obj %0d",
                        $time, got.out_tag, got.stop_event, got.clip_object);
            return;
         end
         want = clip_q[0];
         clip_q.delete(0);
         check_field("out_tag", want.out_tag, got.out_tag);
         check_field("stop_event", TAG_W'(want.stop_event), TAG_W'(got.stop_event));
         check_field("first_of_clip", TAG_W'(want.first_of_clip), TAG_W'(got.first_of_clip));
         check_field("clip_object", TAG_W'(want.clip_object), TAG_W'(got.clip_object));
         check_field("last", TAG_W'(want.last), TAG_W'(got.last));
      endfunction

      function int pending();
         return clip_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   req_free = 1'b0;
   bit   rsp_free = 1'b0;
   int   items_sent = 0;

   clip_scoreboard sb = new();

   pptr_chan_if #(.payload_type(req_payload_type)) req_if ();
   pptr_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   pptr_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   pre_post_trigger_recorder #(
      .RING_DEPTH(RING_N),
      .TAG_BITS  (TAG_W)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #1 clock = ~clock;

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_quiet();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(0, 6);
      return $urandom_range(20, 70);
   endfunction

   // a class the current mask allows, if it allows any, so that sequences actually trigger
   function automatic logic [CLASS_W-1:0] pick_flag_class();
      logic [CLASS_W-1:0] c;
      c = CLASS_W'($urandom_range(1, 63));
      if (sb.mask_cfg[63:1] == '0)
         return c;
      while (!sb.mask_cfg[c])
         c = CLASS_W'($urandom_range(1, 63));
      return c;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.payload);
   end

   initial begin : rsp_stall_gen
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = rsp_free ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // leaves valid high; the caller lowers it once the burst of writes is done
   task automatic csr_transfer(input logic [REGIDX_W-1:0] idx, input logic [MASK_W-1:0] val);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= '{reg_index: idx, wdata: val};
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic program_regs(input logic [PRE_W-1:0] pre, input logic [POST_W-1:0] post,
                               input logic [MASK_W-1:0] mask, input bit poke_spare);
      csr_transfer(CSR_PRE_COUNT, MASK_W'(pre));
      csr_transfer(CSR_POST_COUNT, MASK_W'(post));
      csr_transfer(CSR_WORTHY_MASK, mask);
      if (poke_spare)
         csr_transfer(CSR_SPARE, {$urandom(), $urandom()});
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_frame(input logic [TAG_W-1:0] tag, input logic mot,
                             input logic [CLASS_W-1:0] cls);
      req_payload_type f;
      int gap;
      f = '{frame_tag: tag, motion: mot, object_class: cls};
      gap = req_free ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= f;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_frame(f);
      items_sent++;
   endtask

   // the last frame is already taken, so valid drops before waiting
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // quiet lead-in, a flagging frame, a motion burst and a motion-free tail;
   // some episodes are pure noise or cut short
   task automatic run_episode(input int quiet);
      int shape, tail_n;
      logic [CLASS_W-1:0] cls;
      shape = $urandom_range(0, 99);
      if (shape < 15) begin
         repeat ($urandom_range(1, 5))
            send_frame($urandom(), 1'($urandom_range(0, 1)), CLASS_W'($urandom_range(0, 63)));
         return;
      end
      cls = pick_flag_class();
      repeat (quiet)
         send_frame($urandom(), $urandom_range(0, 3) == 0,
                    ($urandom_range(0, 3) == 0) ? CLASS_W'($urandom_range(1, 63)) : '0);
      send_frame($urandom(), 1'($urandom_range(0, 1)), cls);
      if (shape < 25)
         return;
      repeat ($urandom_range(1, 4))
         send_frame($urandom(), 1'b1, ($urandom_range(0, 2) == 0) ? cls : '0);
      if (shape < 35)
         return;
      tail_n = (sb.post_cfg > 6) ? $urandom_range(0, 8) : $urandom_range(0, sb.post_cfg + 2);
      repeat (tail_n)
         send_frame($urandom(), 1'b0, '0);
      if ($urandom_range(0, 9) == 0)
         wait_drained();
   endtask

   initial begin : stimulus
      int goal;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero pre_count and zero post_count, every class allowed
      program_regs('0, '0, '1, 1'b0);
      send_frame('0, 1'b1, '0);
      send_frame('1, 1'b1, 6'd63);
      send_frame(32'h1234_5678, 1'b0, '0);
      send_frame(32'hA5A5_A5A5, 1'b0, '0);
      wait_drained();
      repeat (12) @(posedge clock);

      // small ring, only class 5 worthy (bit 0 set but meaningless)
      program_regs(7'd4, 16'd2, 64'h21, 1'b0);
      for (int i = 0; i < 6; i++)
         send_frame(32'h0000_0100 + i, 1'b0, '0);
      send_frame(32'h0000_0200, 1'b1, 6'd7);
      send_frame(32'h0000_0201, 1'b0, 6'd5);
      send_frame(32'h0000_0202, 1'b1, '0);
      send_frame(32'h0000_0203, 1'b1, '0);
      send_frame(32'h0000_0204, 1'b0, '0);
      send_frame(32'h0000_0205, 1'b0, '0);
      wait_drained();
      repeat (12) @(posedge clock);

      // pre_count lowered under a fuller ring, top class only, stray index written
      program_regs(7'd1, '0, 64'h8000_0000_0000_0000, 1'b1);
      send_frame(32'hFFFF_0000, 1'b1, 6'd63);
      send_frame(32'h0000_FFFF, 1'b0, '0);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         repeat (12) @(posedge clock);
         case (ph)
            0: program_regs(7'd64, 16'd3, '1, 1'b0);
            1: program_regs(7'd127, '0, {$urandom(), $urandom()}, 1'b0);
            2: program_regs('0, 16'd1, 64'd1 << $urandom_range(1, 63), 1'b0);
            3: program_regs(PRE_W'($urandom_range(1, 63)), POST_W'($urandom_range(2, 8)),
                            {$urandom(), $urandom()}, 1'b1);
            4: program_regs(7'd64, 16'hFFFF, '1, 1'b0);
            5: program_regs(PRE_W'($urandom_range(0, 127)), POST_W'($urandom_range(0, 4)),
                            '0, 1'b0);
            6: program_regs(7'd1, 16'd2, {$urandom(), $urandom()}, 1'b0);
            default: program_regs(PRE_W'($urandom_range(0, 127)),
                                  POST_W'($urandom_range(0, 20)), {$urandom(), $urandom()},
                                  1'b1);
         endcase
         req_free = (ph % 3 == 0);
         rsp_free = (ph % 4 == 1);
         goal = items_sent + 45;
         // first phase: a quiet lead-in of 70 frames, longer than the ring depth
         if (ph == 0)
            run_episode(70);
         while (items_sent < goal)
            run_episode(pick_quiet());
      end
      req_if.valid <= 1'b0;

      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d frames, %0d result transfers, %0d clips started, %0d stopped",
               sb.frames, sb.results, sb.clips, sb.stops);
      $display("%0d register writes over ring sizes 0 to 127, hold 0 to 65535, masks empty to full",
               sb.writes);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
